/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SMM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, switched off while reset is asserted.
`define SMM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* hw/rtl/smm_pkg.sv */
// Shared constants, command codes and interface structs of the matrix multiplier.
`default_nettype none

package smm_pkg;

    localparam int DIM_DEFAULT = 8;
    localparam int IDX_W       = 3;
    localparam int DATA_W      = 8;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int MEM_DEPTH   = 1 << ADDR_W;

    localparam logic [DATA_W-1:0] SAT_MAX = 8'd255;

    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              rd;
        logic              rd_first;
        logic              rd_last;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              emit;
        logic [IDX_W-1:0]  emit_row;
        logic [IDX_W-1:0]  emit_col;
        logic              emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/smm_ctrl.sv */
// Controller state machine that sequences element loads and the compute sweep.
`default_nettype none

module smm_ctrl #(
    parameter int DIM = smm_pkg::DIM_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_valid,
    input  wire logic [1:0]                command,
    input  wire logic [smm_pkg::IDX_W-1:0] row,
    input  wire logic [smm_pkg::IDX_W-1:0] col,
    output logic                           cmd_stall,
    output smm_pkg::dp_cmd_t               dp_cmd,
    input  wire smm_pkg::dp_status_t       dp_status
);

    localparam logic [smm_pkg::IDX_W-1:0] DIM_LAST = smm_pkg::IDX_W'(DIM - 1);
    localparam logic [smm_pkg::IDX_W:0]   DIM_W    = (smm_pkg::IDX_W + 1)'(DIM);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [smm_pkg::IDX_W-1:0]   i_reg, i_next;
    logic [smm_pkg::IDX_W-1:0]   j_reg, j_next;
    logic [smm_pkg::IDX_W-1:0]   k_reg, k_next;
    logic                        accept;
    logic                        in_range;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign in_range  = ({1'b0, row} < DIM_W) && ({1'b0, col} < DIM_W);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;

        dp_cmd           = '0;
        dp_cmd.rd_addr_a = {i_reg, k_reg};
        dp_cmd.rd_addr_b = {k_reg, j_reg};
        dp_cmd.rd_first  = (k_reg == '0);
        dp_cmd.rd_last   = (k_reg == DIM_LAST);
        dp_cmd.emit_row  = i_reg;
        dp_cmd.emit_col  = j_reg;
        dp_cmd.emit_last = (i_reg == DIM_LAST) && (j_reg == DIM_LAST);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        smm_pkg::CMD_WRITE_A: dp_cmd.wr_a = in_range;
                        smm_pkg::CMD_WRITE_B: dp_cmd.wr_b = in_range;
                        smm_pkg::CMD_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                dp_cmd.rd = 1'b1;
                if (k_reg == DIM_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The finished element moves to the output register once it is free.
                if (dp_status.acc_done && dp_status.out_free)
                begin
                    dp_cmd.emit = 1'b1;
                    if (dp_cmd.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        if (j_reg == DIM_LAST)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/smm_datapath.sv */
// Datapath: operand stores, multiply-accumulate pipeline and output register.
`default_nettype none

module smm_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [smm_pkg::IDX_W-1:0]  row,
    input  wire logic [smm_pkg::IDX_W-1:0]  col,
    input  wire logic [smm_pkg::DATA_W-1:0] element_value,
    input  wire smm_pkg::dp_cmd_t           dp_cmd,
    output smm_pkg::dp_status_t             dp_status,
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output logic [smm_pkg::IDX_W-1:0]       out_row,
    output logic [smm_pkg::IDX_W-1:0]       out_col,
    output logic [smm_pkg::DATA_W-1:0]      product_value,
    output logic                            last
);

    logic [smm_pkg::DATA_W-1:0] mem_a [smm_pkg::MEM_DEPTH];
    logic [smm_pkg::DATA_W-1:0] mem_b [smm_pkg::MEM_DEPTH];
    logic [smm_pkg::MEM_DEPTH-1:0] a_vld_reg;
    logic [smm_pkg::MEM_DEPTH-1:0] b_vld_reg;
    logic [smm_pkg::ADDR_W-1:0]    wr_addr;

    logic [smm_pkg::DATA_W-1:0] a_rd_reg;
    logic [smm_pkg::DATA_W-1:0] b_rd_reg;
    logic                       a_hit_reg;
    logic                       b_hit_reg;
    logic                       s1_vld_reg, s1_first_reg, s1_last_reg;

    logic [smm_pkg::PROD_W-1:0] prod_reg;
    logic                       s2_vld_reg, s2_first_reg, s2_last_reg;

    logic [smm_pkg::DATA_W-1:0]   acc_reg;
    logic                         acc_done_reg;
    logic [smm_pkg::DATA_W-1:0]   acc_base;
    logic [smm_pkg::PROD_W:0]     acc_sum;
    logic [smm_pkg::DATA_W-1:0]   acc_sat;
    logic [smm_pkg::DATA_W-1:0]   op_a;
    logic [smm_pkg::DATA_W-1:0]   op_b;

    logic                       res_valid_reg;
    logic [smm_pkg::IDX_W-1:0]  out_row_reg;
    logic [smm_pkg::IDX_W-1:0]  out_col_reg;
    logic [smm_pkg::DATA_W-1:0] product_reg;
    logic                       last_reg;

    assign wr_addr = {row, col};

    // Store arrays; an entry never written since reset enters the multiplier as zero.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.wr_a)
        begin
            mem_a[wr_addr] <= element_value;
        end
        if (dp_cmd.wr_b)
        begin
            mem_b[wr_addr] <= element_value;
        end
        a_rd_reg <= mem_a[dp_cmd.rd_addr_a];
        b_rd_reg <= mem_b[dp_cmd.rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
            a_hit_reg <= 1'b0;
            b_hit_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.wr_a)
            begin
                a_vld_reg[wr_addr] <= 1'b1;
            end
            if (dp_cmd.wr_b)
            begin
                b_vld_reg[wr_addr] <= 1'b1;
            end
            a_hit_reg <= a_vld_reg[dp_cmd.rd_addr_a];
            b_hit_reg <= b_vld_reg[dp_cmd.rd_addr_b];
        end
    end

    assign op_a = a_hit_reg ? a_rd_reg : '0;
    assign op_b = b_hit_reg ? b_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // The first term of an element starts from zero rather than the old total.
    assign acc_base = s2_first_reg ? '0 : acc_reg;
    assign acc_sum  = (smm_pkg::PROD_W + 1)'(acc_base) + (smm_pkg::PROD_W + 1)'(prod_reg);
    assign acc_sat  = (acc_sum > (smm_pkg::PROD_W + 1)'(smm_pkg::SAT_MAX))
                      ? smm_pkg::SAT_MAX : acc_sum[smm_pkg::DATA_W-1:0];

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            acc_reg <= acc_sat;
        end
        if (dp_cmd.emit)
        begin
            out_row_reg <= dp_cmd.emit_row;
            out_col_reg <= dp_cmd.emit_col;
            product_reg <= acc_reg;
            last_reg    <= dp_cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            acc_done_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= dp_cmd.rd;
            s1_first_reg <= dp_cmd.rd_first;
            s1_last_reg  <= dp_cmd.rd_last;
            s2_vld_reg   <= s1_vld_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;

            if (dp_cmd.emit)
            begin
                acc_done_reg <= 1'b0;
            end
            else if (s2_vld_reg && s2_last_reg)
            begin
                acc_done_reg <= 1'b1;
            end

            if (dp_cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign dp_status.acc_done = acc_done_reg;
    assign dp_status.out_free = !res_valid_reg || !res_stall;

    assign res_valid     = res_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = product_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/saturating_matrix_multiplier.sv */
// Top level of the saturating matrix multiplier: controller plus datapath.
//
//  Channel   Handshake              Payload
//  cmd       cmd_valid / cmd_stall  command, row, col, element_value
//  res       res_valid / res_stall  out_row, out_col, product_value, last
//
// A load transfer does not stall the command channel; the next one can follow at once.
// A compute transfer yields DIM*DIM results, one after another, paced by the single
// multiply-accumulate unit fed through the registered store reads.
// Reset clears per-entry valid bits at once, so no clearing pass is needed.
// While res_stall holds a result, the next finished element waits in the accumulator.
`default_nettype none

module saturating_matrix_multiplier #(
    parameter int DIM = smm_pkg::DIM_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_stall,
    input  wire logic [1:0]                 command,
    input  wire logic [smm_pkg::IDX_W-1:0]  row,
    input  wire logic [smm_pkg::IDX_W-1:0]  col,
    input  wire logic [smm_pkg::DATA_W-1:0] element_value,
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output logic [smm_pkg::IDX_W-1:0]       out_row,
    output logic [smm_pkg::IDX_W-1:0]       out_col,
    output logic [smm_pkg::DATA_W-1:0]      product_value,
    output logic                            last
);

    smm_pkg::dp_cmd_t    dp_cmd;
    smm_pkg::dp_status_t dp_status;

    smm_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .command   (command),
        .row       (row),
        .col       (col),
        .cmd_stall (cmd_stall),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    smm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .row           (row),
        .col           (col),
        .element_value (element_value),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last          (last)
    );

endmodule

`default_nettype wire

/* hw/rtl/smm_checker.sv */
// Port-level checker for the matrix multiplier, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module smm_checker #(
    parameter int DIM = smm_pkg::DIM_DEFAULT
) (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       cmd_valid,
    input wire logic                       cmd_stall,
    input wire logic [1:0]                 command,
    input wire logic                       res_valid,
    input wire logic                       res_stall,
    input wire logic [smm_pkg::IDX_W-1:0]  out_row,
    input wire logic [smm_pkg::IDX_W-1:0]  out_col,
    input wire logic [smm_pkg::DATA_W-1:0] product_value,
    input wire logic                       last
);

    localparam logic [smm_pkg::IDX_W-1:0] DIM_LAST = smm_pkg::IDX_W'(DIM - 1);

    // A stalled result must hold its row, column and value.
    `SMM_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && res_stall,
        res_valid && $stable(product_value) && $stable(out_row) && $stable(out_col))

    // The end-of-run mark sits exactly on the bottom-right element.
    `SMM_ASSERT_IMP(a_last_pos, clk, rst_n, res_valid && last,
        (out_row == DIM_LAST) && (out_col == DIM_LAST))
    `SMM_ASSERT_IMP(a_last_mark, clk, rst_n,
        res_valid && (out_row == DIM_LAST) && (out_col == DIM_LAST), last)

    // A compute transfer blocks further commands while the sweep runs.
    `SMM_ASSERT_NXT(a_compute_busy, clk, rst_n,
        cmd_valid && !cmd_stall && (command == smm_pkg::CMD_COMPUTE), cmd_stall)

endmodule

bind saturating_matrix_multiplier smm_checker #(
    .DIM (DIM)
) u_smm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .command       (command),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .last          (last)
);

`default_nettype wire
